// ===== rtl/core/euler_to_rotation_matrix_assert.svh =====
`ifndef EULER_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_ASSERT_SVH
// implication checked on every clock edge outside reset
`define E2R_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define E2R_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/e2r_pkg.sv =====
package e2r_pkg;
    localparam int AngW = 16;
    localparam int IntW = 34;
    localparam int TabLen = 24;
    localparam int DefTrigStages = 16;
    localparam int DefOutFracBits = 14;
    localparam int OutW = 16;
    localparam logic signed [IntW-1:0] Q30Gain = 34'sd652032874;
    localparam logic signed [IntW-1:0] Q30HalfPi = 34'sd1686629713;
    localparam logic signed [IntW-1:0] Q30Pi = 34'sd3373259426;

    function automatic logic signed [IntW-1:0] atan_q30(input int i);
        logic signed [IntW-1:0] r;
        case (i)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default: r = IntW'(64'sd1 << (30 - i));
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic signed [IntW-1:0] s;
        logic signed [IntW-1:0] c;
    } sc_t;
endpackage

// ===== rtl/core/e2r_cordic.sv =====
module e2r_cordic import e2r_pkg::*; #(
    parameter int TRIG_STAGES = DefTrigStages
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [AngW-1:0] angle,
    output sc_t                    sc
);
    localparam int N = (TRIG_STAGES > TabLen) ? TabLen : TRIG_STAGES;

    logic signed [IntW-1:0] x_reg [0:N];
    logic signed [IntW-1:0] y_reg [0:N];
    logic signed [IntW-1:0] z_reg [0:N];
    logic                   neg_reg [0:N];
    logic signed [IntW-1:0] z0;

    always_comb begin
        z0 = IntW'(angle) <<< 17;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= Q30Gain;
            y_reg[0] <= '0;
            if (z0 > Q30HalfPi) begin
                z_reg[0] <= z0 - Q30Pi;
                neg_reg[0] <= 1'b1;
            end else if (z0 < -Q30HalfPi) begin
                z_reg[0] <= z0 + Q30Pi;
                neg_reg[0] <= 1'b1;
            end else begin
                z_reg[0] <= z0;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                neg_reg[i+1] <= neg_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
            end
        end
    end

    assign sc.s = neg_reg[N] ? -y_reg[N] : y_reg[N];
    assign sc.c = neg_reg[N] ? -x_reg[N] : x_reg[N];
endmodule

// ===== rtl/core/e2r_merge.sv =====
module e2r_merge import e2r_pkg::*; #(
    parameter int OUT_FRAC_BITS = DefOutFracBits
) (
    input  logic                  aclk,
    input  logic                  en,
    input  sc_t                   rs,
    input  sc_t                   ps,
    input  sc_t                   ys,
    output logic [9*OutW-1:0]     mat
);
    localparam int Sh = 60 - OUT_FRAC_BITS;
    localparam logic signed [67:0] One = 68'sd1 <<< OUT_FRAC_BITS;
    localparam logic signed [67:0] Half = 68'sd1 <<< (Sh - 1);

    // stage a: pass trig through, sp*cy and sp*sy
    sc_t rs_a_reg, ps_a_reg, ys_a_reg;
    logic signed [67:0] spcy_p_reg, spsy_p_reg;
    // stage b: rounded products
    sc_t rs_b_reg, ps_b_reg, ys_b_reg;
    logic signed [IntW-1:0] spcy_b_reg, spsy_b_reg;
    // stage c: q60 products
    logic signed [67:0] p_reg [0:13];
    // stage d: sums
    logic signed [68:0] sum_reg [0:8];

    function automatic logic [OutW-1:0] to_out(input logic signed [68:0] v);
        logic signed [68:0] t;
        t = (v + 69'(Half)) >>> Sh;
        if (t > 69'(One)) t = 69'(One);
        if (t < -69'(One)) t = -69'(One);
        return t[OutW-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            rs_a_reg <= rs;
            ps_a_reg <= ps;
            ys_a_reg <= ys;
            spcy_p_reg <= 68'(ps.s) * 68'(ys.c);
            spsy_p_reg <= 68'(ps.s) * 68'(ys.s);
            rs_b_reg <= rs_a_reg;
            ps_b_reg <= ps_a_reg;
            ys_b_reg <= ys_a_reg;
            spcy_b_reg <= IntW'((spcy_p_reg + (68'sd1 <<< 29)) >>> 30);
            spsy_b_reg <= IntW'((spsy_p_reg + (68'sd1 <<< 29)) >>> 30);
            p_reg[0] <= 68'(ps_b_reg.c) * 68'(ys_b_reg.c);
            p_reg[1] <= 68'(rs_b_reg.c) * 68'(ys_b_reg.s);
            p_reg[2] <= 68'(rs_b_reg.s) * 68'(spcy_b_reg);
            p_reg[3] <= 68'(rs_b_reg.s) * 68'(ys_b_reg.s);
            p_reg[4] <= 68'(rs_b_reg.c) * 68'(spcy_b_reg);
            p_reg[5] <= 68'(ps_b_reg.c) * 68'(ys_b_reg.s);
            p_reg[6] <= 68'(rs_b_reg.c) * 68'(ys_b_reg.c);
            p_reg[7] <= 68'(rs_b_reg.s) * 68'(spsy_b_reg);
            p_reg[8] <= 68'(rs_b_reg.s) * 68'(ys_b_reg.c);
            p_reg[9] <= 68'(rs_b_reg.c) * 68'(spsy_b_reg);
            p_reg[10] <= -(68'(ps_b_reg.s) <<< 30);
            p_reg[11] <= 68'(rs_b_reg.s) * 68'(ps_b_reg.c);
            p_reg[12] <= 68'(rs_b_reg.c) * 68'(ps_b_reg.c);
            p_reg[13] <= '0;
            sum_reg[0] <= 69'(p_reg[0]);
            sum_reg[1] <= 69'(p_reg[2]) - 69'(p_reg[1]);
            sum_reg[2] <= 69'(p_reg[3]) + 69'(p_reg[4]);
            sum_reg[3] <= 69'(p_reg[5]);
            sum_reg[4] <= 69'(p_reg[6]) + 69'(p_reg[7]);
            sum_reg[5] <= 69'(p_reg[9]) - 69'(p_reg[8]);
            sum_reg[6] <= 69'(p_reg[10]) + 69'(p_reg[13]);
            sum_reg[7] <= 69'(p_reg[11]);
            sum_reg[8] <= 69'(p_reg[12]);
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_out
        assign mat[k*OutW +: OutW] = to_out(sum_reg[k]);
    end
endmodule

// ===== rtl/core/euler_to_rotation_matrix.sv =====
// path: three cordic lanes (input register, then their stages), then merge stages a, b, c and d
// throughput: one beat per cycle unless stalled; all stages are fully pipelined
// the whole pipeline advances whenever the output register is free or being taken
// reset: aresetn (synchronous, active low) clears only the valid flags
module euler_to_rotation_matrix import e2r_pkg::*; #(
    parameter int TRIG_STAGES = DefTrigStages,
    parameter int OUT_FRAC_BITS = DefOutFracBits
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [47:0]     s_tdata,  // roll_angle, pitch_angle, yaw_angle
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [143:0]    m_tdata   // r00 r01 r02 r10 r11 r12 r20 r21 r22
);
    localparam int N = (TRIG_STAGES > TabLen) ? TabLen : TRIG_STAGES;
    localparam int Lat = N + 5;

    logic [Lat-1:0] vld_reg, vld_next;
    logic           en;
    sc_t            rs, ps, ys;

    // stall-all pipeline: advance when the last slot is empty or drained
    assign en = !vld_reg[Lat-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[Lat-1];

    always_comb begin
        vld_next = {vld_reg[Lat-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    e2r_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_roll (
        .aclk(aclk), .en(en), .angle(s_tdata[15:0]), .sc(rs));
    e2r_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_pitch (
        .aclk(aclk), .en(en), .angle(s_tdata[31:16]), .sc(ps));
    e2r_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_yaw (
        .aclk(aclk), .en(en), .angle(s_tdata[47:32]), .sc(ys));

    e2r_merge #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_merge (
        .aclk(aclk), .en(en), .rs(rs), .ps(ps), .ys(ys), .mat(m_tdata));
endmodule

// ===== rtl/core/e2r_checker.sv =====
`include "euler_to_rotation_matrix_assert.svh"
module e2r_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);
    `E2R_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "valid dropped")
    `E2R_ASSERT_NXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "data moved")
    `E2R_ASSERT_IMP(a_ready_free, aclk, aresetn, !m_tvalid, s_tready, "not ready while output empty")
    `E2R_ASSERT_IMP(a_ready_drain, aclk, aresetn, m_tready, s_tready, "not ready while draining")
endmodule

bind euler_to_rotation_matrix e2r_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
